/* rtl/sidx_pkg.sv */
package sidx_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhHeader = 2'd1,
    PhEntry  = 2'd2,
    PhSkip   = 2'd3
  } phase_e;

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindEntry  = 2'd1,
    KindShort  = 2'd2
  } result_kind_e;

  // Header byte positions (index of the byte that completes a field).
  localparam logic [5:0] HdrVersion     = 6'd0;
  localparam logic [5:0] HdrStreamIdEnd = 6'd7;
  localparam logic [5:0] HdrTicksEnd    = 6'd11;
  localparam logic [5:0] HdrEarly32End  = 6'd15;
  localparam logic [5:0] HdrOffset32End = 6'd19;
  localparam logic [5:0] HdrCount32End  = 6'd23;
  localparam logic [5:0] HdrEarly64End  = 6'd19;
  localparam logic [5:0] HdrOffset64End = 6'd27;
  localparam logic [5:0] HdrCount64End  = 6'd31;

  // Reference entry byte positions.
  localparam logic [3:0] EntWordOneEnd = 4'd3;
  localparam logic [3:0] EntWordTwoEnd = 4'd7;
  localparam logic [3:0] EntLastByte   = 4'd11;

  localparam int unsigned ResultDataW = 304;

  // One result item.
  typedef struct packed {
    result_kind_e kind;
    logic [31:0]  stream_id;
    logic [31:0]  ticks_per_second;
    logic [63:0]  earliest_time;
    logic [63:0]  offset_to_first;
    logic [15:0]  entry_count;
    logic         points_to_index;
    logic [30:0]  referenced_bytes;
    logic [31:0]  subsegment_duration;
    logic         begins_with_access_point;
    logic [2:0]   access_point_type;
    logic [27:0]  access_point_delta;
  } result_t;

endpackage

/* rtl/segment_index_box_parser_top.sv */
// Segment index box parser. Payload bytes of an index box enter one per
// transaction on the slave stream, big-endian, with tuser marking the first
// byte (which restarts parsing) and tlast marking the final byte. The block
// gives one header result when the reference count completes, one entry
// result on the last byte of each 12-byte reference, and a box-too-short
// result when the final byte comes before the header or the announced
// references are complete. Bytes before a first mark and after the last
// reference give nothing. The parse state is updated by a shift and counter
// step per byte, so a byte can be accepted in every cycle while tready is
// high. A result is registered in the output register, or in a one-deep
// skid register while an earlier result waits there; the skid register keeps
// the input open while one result waits, and tready drops only when both are
// full.
module segment_index_box_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser_i,   // [0] payload_first
  input  logic         s_axis_tlast_i,   // payload_last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] stream_id, [63:32] ticks_per_second, [127:64] earliest_time,
  // [191:128] offset_to_first, [207:192] entry_count, [208] points_to_index,
  // [239:209] referenced_bytes, [271:240] subsegment_duration,
  // [272] begins_with_access_point, [275:273] access_point_type,
  // [303:276] access_point_delta
  output logic [sidx_pkg::ResultDataW-1:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o    // [1:0] result_kind
);

  // Parse state.
  sidx_pkg::phase_e phase_q, phase_d;
  logic [5:0]  hdr_idx_q, hdr_idx_d;
  logic        wide_q, wide_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] stream_id_q, stream_id_d;
  logic [31:0] ticks_q, ticks_d;
  logic [63:0] earliest_q, earliest_d;
  logic [63:0] first_off_q, first_off_d;
  logic [15:0] entries_q, entries_d;
  logic [3:0]  ent_idx_q, ent_idx_d;
  logic [31:0] ent_word_q, ent_word_d;
  logic [31:0] duration_q, duration_d;

  // Output and skid stages.
  logic                out_valid_q, skid_valid_q;
  sidx_pkg::result_t   out_q, skid_q, res;
  logic                res_valid;

  logic in_fire, out_pop;
  logic first, last;
  logic [7:0] data_byte;

  // Values after an optional restart on the first mark.
  sidx_pkg::phase_e cur_phase;
  logic [5:0]  cur_hdr_idx;
  logic        cur_wide;
  logic [63:0] cur_acc;
  logic [15:0] cur_entries;
  logic [3:0]  cur_ent_idx;
  logic [63:0] acc_shift;
  logic [31:0] word;
  logic [5:0]  e_end, o_end, c_end;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop   = out_valid_q && m_axis_tready_i;
  assign data_byte = s_axis_tdata_i;
  assign first     = s_axis_tuser_i[0];
  assign last      = s_axis_tlast_i;

  // Byte parser: one shift and index step per transaction.
  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    wide_d      = wide_q;
    acc_d       = acc_q;
    stream_id_d = stream_id_q;
    ticks_d     = ticks_q;
    earliest_d  = earliest_q;
    first_off_d = first_off_q;
    entries_d   = entries_q;
    ent_idx_d   = ent_idx_q;
    ent_word_d  = ent_word_q;
    duration_d  = duration_q;
    res         = '0;
    res_valid   = 1'b0;

    cur_phase   = first ? sidx_pkg::PhHeader : phase_q;
    cur_hdr_idx = first ? 6'd0 : hdr_idx_q;
    cur_wide    = first ? 1'b0 : wide_q;
    cur_acc     = first ? 64'd0 : acc_q;
    cur_entries = first ? 16'd0 : entries_q;
    cur_ent_idx = first ? 4'd0 : ent_idx_q;
    if (in_fire && first) begin
      stream_id_d = '0;
      ticks_d     = '0;
      earliest_d  = '0;
      first_off_d = '0;
      ent_word_d  = '0;
      duration_d  = '0;
    end

    acc_shift = {cur_acc[55:0], data_byte};
    word      = acc_shift[31:0];
    e_end     = cur_wide ? sidx_pkg::HdrEarly64End  : sidx_pkg::HdrEarly32End;
    o_end     = cur_wide ? sidx_pkg::HdrOffset64End : sidx_pkg::HdrOffset32End;
    c_end     = cur_wide ? sidx_pkg::HdrCount64End  : sidx_pkg::HdrCount32End;

    if (in_fire && cur_phase != sidx_pkg::PhIdle) begin
      phase_d   = cur_phase;
      hdr_idx_d = cur_hdr_idx;
      wide_d    = cur_wide;
      acc_d     = acc_shift;
      entries_d = cur_entries;
      ent_idx_d = cur_ent_idx;

      case (cur_phase)
        sidx_pkg::PhHeader: begin
          if (cur_hdr_idx == sidx_pkg::HdrVersion) begin
            wide_d = (data_byte != 8'd0);
          end else if (cur_hdr_idx == sidx_pkg::HdrStreamIdEnd) begin
            stream_id_d = word;
          end else if (cur_hdr_idx == sidx_pkg::HdrTicksEnd) begin
            ticks_d = word;
          end else if (cur_hdr_idx == e_end) begin
            earliest_d = cur_wide ? acc_shift : {32'd0, word};
          end else if (cur_hdr_idx == o_end) begin
            first_off_d = cur_wide ? acc_shift : {32'd0, word};
          end

          if (cur_hdr_idx == c_end) begin
            entries_d = word[15:0];
            acc_d     = '0;
            phase_d   = (word[15:0] != 16'd0) ? sidx_pkg::PhEntry : sidx_pkg::PhSkip;
            res_valid             = 1'b1;
            res.kind              = sidx_pkg::KindHeader;
            res.stream_id         = stream_id_d;
            res.ticks_per_second  = ticks_d;
            res.earliest_time     = earliest_d;
            res.offset_to_first   = first_off_d;
            res.entry_count       = word[15:0];
          end else begin
            hdr_idx_d = cur_hdr_idx + 6'd1;
          end
        end
        sidx_pkg::PhEntry: begin
          if (cur_ent_idx == sidx_pkg::EntWordOneEnd) begin
            ent_word_d = word;
            ent_idx_d  = cur_ent_idx + 4'd1;
          end else if (cur_ent_idx == sidx_pkg::EntWordTwoEnd) begin
            duration_d = word;
            ent_idx_d  = cur_ent_idx + 4'd1;
          end else if (cur_ent_idx >= sidx_pkg::EntLastByte) begin
            res_valid                    = 1'b1;
            res.kind                     = sidx_pkg::KindEntry;
            res.points_to_index          = ent_word_q[31];
            res.referenced_bytes         = ent_word_q[30:0];
            res.subsegment_duration      = duration_q;
            res.begins_with_access_point = word[31];
            res.access_point_type        = word[30:28];
            res.access_point_delta       = word[27:0];
            entries_d = cur_entries - 16'd1;
            ent_idx_d = '0;
            acc_d     = '0;
            if (cur_entries == 16'd1) begin
              phase_d = sidx_pkg::PhSkip;
            end
          end else begin
            ent_idx_d = cur_ent_idx + 4'd1;
          end
        end
        default: begin
        end
      endcase

      // Final byte: an unfinished box replaces any result with an error.
      if (last) begin
        if (phase_d != sidx_pkg::PhSkip) begin
          res       = '0;
          res.kind  = sidx_pkg::KindShort;
          res_valid = 1'b1;
        end
        phase_d = sidx_pkg::PhIdle;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sidx_pkg::PhIdle;
      hdr_idx_q    <= '0;
      wide_q       <= 1'b0;
      entries_q    <= '0;
      ent_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      wide_q    <= wide_d;
      entries_q <= entries_d;
      ent_idx_q <= ent_idx_d;
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid_q && !out_pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    stream_id_q <= stream_id_d;
    ticks_q     <= ticks_d;
    earliest_q  <= earliest_d;
    first_off_q <= first_off_d;
    ent_word_q  <= ent_word_d;
    duration_q  <= duration_d;
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // Master stream.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {out_q.access_point_delta, out_q.access_point_type,
                            out_q.begins_with_access_point, out_q.subsegment_duration,
                            out_q.referenced_bytes, out_q.points_to_index,
                            out_q.entry_count, out_q.offset_to_first,
                            out_q.earliest_time, out_q.ticks_per_second,
                            out_q.stream_id};

  // The skid register only fills behind a waiting output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result without an output result");

  // While references are being read, at least one is still outstanding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sidx_pkg::PhEntry) |-> (entries_q != 16'd0))
    else $error("entry phase with no references left");

  // Entry byte index wraps at the end of each reference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_idx_q <= sidx_pkg::EntLastByte)
    else $error("entry byte index beyond reference length");

  // Header byte index never passes the wide count end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_idx_q <= sidx_pkg::HdrCount64End)
    else $error("header byte index beyond header length");

endmodule
